@@ src/csimt_pkg.sv @@
// Shared types and constants of the motion turbulence block.
// Depends on nothing; used by every module under src.
package csimt_pkg;

   localparam int SUBCARRIERS = 64;
   localparam int IDX_W       = $clog2(SUBCARRIERS);
   localparam int POS_W       = $clog2(SUBCARRIERS + 1);

   localparam int DIV_W   = 24;
   localparam int DVS_W   = 16;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int RAD_W   = 32;
   localparam int ROOT_W  = 16;
   localparam int SCNT_W  = $clog2(ROOT_W + 1);

   localparam logic [1:0]  REG_SLOW_ALPHA   = 2'd0;
   localparam logic [1:0]  REG_OUT_ALPHA    = 2'd1;
   localparam logic [1:0]  REG_ACTIVE_FLOOR = 2'd2;

   localparam logic [15:0] SLOW_ALPHA_RST   = 16'd655;
   localparam logic [15:0] OUT_ALPHA_RST    = 16'd13107;
   localparam logic [15:0] ACTIVE_FLOOR_RST = 16'd512;
   localparam logic [15:0] PEAK_RST         = 16'd256;
   localparam logic [23:0] WEIGHT_ONE       = 24'h010000;
   localparam logic [23:0] DEV_MAX          = 24'hFFFFFF;
   localparam logic [15:0] BAR_SCALE        = 16'd65280;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

@@ src/csi_motion_turbulence.sv @@
// Top level of the motion turbulence block: control sequencer, mean and bar memories.
// Depends on csimt_pkg, csimt_div and csimt_sqrt.
//
// Usage: one beat on req_ carries one subcarrier sample or a clear command.
// A valid sample beat holds req_ready low for the square root, the weight
// division and the mean read-modify-write, plus the relative deviation when
// the mean is above the floor; all divisions run in turn on the shared one
// bit per cycle divider. An invalid or surplus sample starts no square root
// or division. The beat that carries frame_end then runs the turbulence
// update when any subcarrier was active, and returns one rsp_ beat per
// subcarrier of the frame, each after its bar division and any receiver stall.
// req_ready is low from acceptance until the item, and for a frame end all
// of its bars, is finished. A stalled receiver simply holds the current bar
// on rsp_ until taken; no further input is accepted meanwhile.
// A clear beat returns nothing and leaves the block idle.
// Reset loads the register defaults and clears all learned state at once;
// the mean memory carries a valid bit per entry, so no clearing pass runs.
// Registers on csr_: 0 slow_alpha, 1 out_alpha, 2 active_floor, write only
// while idle.
module csi_motion_turbulence (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic signed [7:0] req_imag_part,
   input  logic signed [7:0] req_real_part,
   input  logic        req_invalid_flag,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_subcarrier_index,
   output logic [7:0]  rsp_amplitude_bar,
   output logic [15:0] rsp_turbulence,
   output logic [6:0]  rsp_subcarrier_count,
   output logic        rsp_last_bar,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SUB = csimt_pkg::SUBCARRIERS;
   localparam int IW  = csimt_pkg::IDX_W;
   localparam int PW  = csimt_pkg::POS_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQRT   = 4'd1;
   localparam logic [3:0] S_WDIV   = 4'd2;
   localparam logic [3:0] S_MMUL   = 4'd3;
   localparam logic [3:0] S_MUPD   = 4'd4;
   localparam logic [3:0] S_RDIV   = 4'd5;
   localparam logic [3:0] S_FEND   = 4'd6;
   localparam logic [3:0] S_TDIV   = 4'd7;
   localparam logic [3:0] S_TMUL   = 4'd8;
   localparam logic [3:0] S_TUPD   = 4'd9;
   localparam logic [3:0] S_BRD    = 4'd10;
   localparam logic [3:0] S_BSTART = 4'd11;
   localparam logic [3:0] S_BDIV   = 4'd12;
   localparam logic [3:0] S_BOUT   = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [15:0] slow_alpha_ff, slow_alpha_in;
   logic [15:0] out_alpha_ff, out_alpha_in;
   logic [15:0] floor_ff, floor_in;
   logic [15:0] fc_ff, fc_in;
   logic [15:0] turb_ff, turb_in;
   logic [23:0] dev_ff, dev_in;
   logic [6:0]  act_ff, act_in;
   logic [15:0] peak_ff, peak_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] bar_idx_ff, bar_idx_in;
   logic        fend_ff, fend_in;
   logic [15:0] amp_ff, amp_in;
   logic [15:0] mean_old_ff, mean_old_in;
   logic [16:0] bl_w_ff, bl_w_in;
   logic [23:0] bl_mag_ff, bl_mag_in;
   logic [15:0] bl_m_ff, bl_m_in;
   logic        bl_neg_ff, bl_neg_in;
   logic [40:0] prod_ff, prod_in;
   logic [SUB-1:0] mean_vld_ff, mean_vld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_idx_ff, rsp_idx_in;
   logic [7:0]  rsp_bar_ff, rsp_bar_in;
   logic [15:0] rsp_turb_ff, rsp_turb_in;
   logic [6:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [15:0] mean_mem [SUB];
   logic [7:0]  bar_mem  [SUB];
   logic [15:0] mean_rd_ff;
   logic        mean_rd_vld_ff;
   logic [7:0]  bar_rd_ff;
   logic        mean_we, bar_we;
   logic [15:0] mean_wdata;
   logic [7:0]  bar_wdata;

   csimt_pkg::div_req_type  div_req;
   csimt_pkg::div_rsp_type  div_rsp;
   csimt_pkg::sqrt_req_type sqrt_req;
   csimt_pkg::sqrt_rsp_type sqrt_rsp;

   logic        req_fire, rsp_fire, csr_wr;
   logic signed [15:0] sq_im, sq_re;
   logic [16:0] sq_sum;
   logic [41:0] bl_round;
   logic [25:0] bl_q;
   logic signed [27:0] bl_r;
   logic [15:0] bl_res;
   logic [15:0] mean_new, dmag;
   logic [16:0] w_frame;
   logic [24:0] dev_sum;
   logic [23:0] bar_num;
   logic [31:0] idx_ext, pos_ext;
   logic [IW-1:0] pos_idx;

   csimt_div  u_div  (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   csimt_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .rsp(sqrt_rsp));

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid_ff && rsp_ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign pos_idx    = pos_ff[IW-1:0];

   always_comb begin
      unique case (csr_paddr[3:2])
         csimt_pkg::REG_SLOW_ALPHA:   csr_prdata = {16'd0, slow_alpha_ff};
         csimt_pkg::REG_OUT_ALPHA:    csr_prdata = {16'd0, out_alpha_ff};
         csimt_pkg::REG_ACTIVE_FLOOR: csr_prdata = {16'd0, floor_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      sq_im    = req_imag_part * req_imag_part;
      sq_re    = req_real_part * req_real_part;
      sq_sum   = 17'(sq_im) + 17'(sq_re);
      bl_round = {1'b0, prod_ff} + 42'd32768;
      bl_q     = bl_round[41:16];
      bl_r     = bl_neg_ff ? (28'(bl_m_ff) - 28'(bl_q)) : (28'(bl_m_ff) + 28'(bl_q));
      if (bl_r < 0)
         bl_res = 16'd0;
      else if (bl_r > 28'sd65535)
         bl_res = 16'hFFFF;
      else
         bl_res = bl_r[15:0];
      mean_new = (mean_old_ff == 16'd0) ? amp_ff : bl_res;
      dmag     = (amp_ff > mean_new) ? (amp_ff - mean_new) : (mean_new - amp_ff);
      w_frame  = (div_rsp.quotient[16:0] < {1'b0, slow_alpha_ff}) ?
                 {1'b0, slow_alpha_ff} : div_rsp.quotient[16:0];
      dev_sum  = {1'b0, dev_ff} +
                 ((div_rsp.quotient > 24'd65535) ? 25'd65535 : 25'(div_rsp.quotient));
      bar_num  = {bar_rd_ff, 16'd0} - {8'd0, bar_rd_ff, 8'd0};
      idx_ext  = 32'(bar_idx_ff);
      pos_ext  = 32'(pos_ff);
   end

   always_comb begin
      state_in      = state_ff;
      slow_alpha_in = slow_alpha_ff;
      out_alpha_in  = out_alpha_ff;
      floor_in      = floor_ff;
      fc_in         = fc_ff;
      turb_in       = turb_ff;
      dev_in        = dev_ff;
      act_in        = act_ff;
      peak_in       = peak_ff;
      pos_in        = pos_ff;
      bar_idx_in    = bar_idx_ff;
      fend_in       = fend_ff;
      amp_in        = amp_ff;
      mean_old_in   = mean_old_ff;
      bl_w_in       = bl_w_ff;
      bl_mag_in     = bl_mag_ff;
      bl_m_in       = bl_m_ff;
      bl_neg_in     = bl_neg_ff;
      prod_in       = prod_ff;
      mean_vld_in   = mean_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_bar_in    = rsp_bar_ff;
      rsp_turb_in   = rsp_turb_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      mean_we       = 1'b0;
      mean_wdata    = mean_new;
      bar_we        = 1'b0;
      bar_wdata     = 8'd0;
      div_req       = '0;
      sqrt_req      = '0;

      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            csimt_pkg::REG_SLOW_ALPHA:   slow_alpha_in = csr_pwdata[15:0];
            csimt_pkg::REG_OUT_ALPHA:    out_alpha_in  = csr_pwdata[15:0];
            csimt_pkg::REG_ACTIVE_FLOOR: floor_in      = csr_pwdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_cmd == csimt_pkg::CMD_CLEAR) begin
                  mean_vld_in = '0;
                  fc_in       = '0;
                  turb_in     = '0;
                  dev_in      = '0;
                  act_in      = '0;
                  peak_in     = csimt_pkg::PEAK_RST;
                  pos_in      = '0;
                  bar_idx_in  = '0;
               end else begin
                  fend_in = req_frame_end;
                  if (pos_ff == '0 && fc_ff != 16'hFFFF)
                     fc_in = fc_ff + 16'd1;
                  if (pos_ff < PW'(SUB) && !req_invalid_flag) begin
                     sqrt_req.start    = 1'b1;
                     sqrt_req.radicand = {sq_sum[15:0], 16'd0};
                     state_in          = S_SQRT;
                  end else begin
                     if (pos_ff < PW'(SUB)) begin
                        bar_we = 1'b1;
                        pos_in = pos_ff + PW'(1);
                     end
                     state_in = req_frame_end ? S_FEND : S_IDLE;
                  end
               end
            end
         end
         S_SQRT: begin
            if (sqrt_rsp.done) begin
               amp_in           = sqrt_rsp.root;
               mean_old_in      = mean_rd_vld_ff ? mean_rd_ff : 16'd0;
               div_req.start    = 1'b1;
               div_req.dividend = csimt_pkg::WEIGHT_ONE;
               div_req.divisor  = fc_ff;
               state_in         = S_WDIV;
            end
         end
         S_WDIV: begin
            if (div_rsp.done) begin
               bl_w_in   = w_frame;
               bl_m_in   = mean_old_ff;
               bl_neg_in = amp_ff < mean_old_ff;
               bl_mag_in = 24'((amp_ff < mean_old_ff) ? (mean_old_ff - amp_ff) :
                               (amp_ff - mean_old_ff));
               state_in  = S_MMUL;
            end
         end
         S_MMUL, S_TMUL: begin
            prod_in  = bl_w_ff * bl_mag_ff;
            state_in = (state_ff == S_MMUL) ? S_MUPD : S_TUPD;
         end
         S_MUPD: begin
            mean_we              = 1'b1;
            mean_vld_in[pos_idx] = 1'b1;
            bar_we               = 1'b1;
            bar_wdata            = amp_ff[15:8];
            if (amp_ff > peak_ff)
               peak_in = amp_ff;
            pos_in = pos_ff + PW'(1);
            if (mean_new > floor_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = {dmag, 8'd0};
               div_req.divisor  = mean_new;
               state_in         = S_RDIV;
            end else begin
               state_in = fend_ff ? S_FEND : S_IDLE;
            end
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               dev_in = dev_sum[24] ? csimt_pkg::DEV_MAX : dev_sum[23:0];
               if (act_ff != 7'd127)
                  act_in = act_ff + 7'd1;
               state_in = fend_ff ? S_FEND : S_IDLE;
            end
         end
         S_FEND: begin
            if (act_ff != 7'd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = dev_ff;
               div_req.divisor  = {9'd0, act_ff};
               state_in         = S_TDIV;
            end else begin
               state_in = S_BRD;
            end
         end
         S_TDIV: begin
            if (div_rsp.done) begin
               bl_w_in   = {1'b0, out_alpha_ff};
               bl_m_in   = turb_ff;
               bl_neg_in = div_rsp.quotient < 24'(turb_ff);
               bl_mag_in = (div_rsp.quotient < 24'(turb_ff)) ?
                           (24'(turb_ff) - div_rsp.quotient) :
                           (div_rsp.quotient - 24'(turb_ff));
               state_in  = S_TMUL;
            end
         end
         S_TUPD: begin
            turb_in  = bl_res;
            state_in = S_BRD;
         end
         S_BRD: begin
            state_in = S_BSTART;
         end
         S_BSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = bar_num;
            div_req.divisor  = peak_ff;
            state_in         = S_BDIV;
         end
         S_BDIV: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ext[5:0];
               rsp_bar_in   = (div_rsp.quotient > 24'd255) ? 8'hFF : div_rsp.quotient[7:0];
               rsp_turb_in  = turb_ff;
               rsp_cnt_in   = pos_ext[6:0];
               rsp_last_in  = (bar_idx_ff + PW'(1)) == pos_ff;
               state_in     = S_BOUT;
            end
         end
         S_BOUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  dev_in     = '0;
                  act_in     = '0;
                  peak_in    = csimt_pkg::PEAK_RST;
                  pos_in     = '0;
                  bar_idx_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  bar_idx_in = bar_idx_ff + PW'(1);
                  state_in   = S_BRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mean_we)
         mean_mem[pos_idx] <= mean_wdata;
      if (bar_we)
         bar_mem[pos_idx] <= bar_wdata;
      mean_rd_ff     <= mean_mem[pos_idx];
      mean_rd_vld_ff <= mean_vld_ff[pos_idx];
      bar_rd_ff      <= bar_mem[bar_idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      fend_ff     <= fend_in;
      amp_ff      <= amp_in;
      mean_old_ff <= mean_old_in;
      bl_w_ff     <= bl_w_in;
      bl_mag_ff   <= bl_mag_in;
      bl_m_ff     <= bl_m_in;
      bl_neg_ff   <= bl_neg_in;
      prod_ff     <= prod_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_bar_ff  <= rsp_bar_in;
      rsp_turb_ff <= rsp_turb_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         slow_alpha_ff <= csimt_pkg::SLOW_ALPHA_RST;
         out_alpha_ff  <= csimt_pkg::OUT_ALPHA_RST;
         floor_ff      <= csimt_pkg::ACTIVE_FLOOR_RST;
         fc_ff         <= '0;
         turb_ff       <= '0;
         dev_ff        <= '0;
         act_ff        <= '0;
         peak_ff       <= csimt_pkg::PEAK_RST;
         pos_ff        <= '0;
         bar_idx_ff    <= '0;
         mean_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slow_alpha_ff <= slow_alpha_in;
         out_alpha_ff  <= out_alpha_in;
         floor_ff      <= floor_in;
         fc_ff         <= fc_in;
         turb_ff       <= turb_in;
         dev_ff        <= dev_in;
         act_ff        <= act_in;
         peak_ff       <= peak_in;
         pos_ff        <= pos_in;
         bar_idx_ff    <= bar_idx_in;
         mean_vld_ff   <= mean_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_subcarrier_index = rsp_idx_ff;
   assign rsp_amplitude_bar    = rsp_bar_ff;
   assign rsp_turbulence       = rsp_turb_ff;
   assign rsp_subcarrier_count = rsp_cnt_ff;
   assign rsp_last_bar         = rsp_last_ff;

   a_rsp_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_BOUT))
      else $error("result beat outside output state");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(SUB))
      else $error("position beyond subcarrier count");
   a_peak_floor: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= csimt_pkg::PEAK_RST)
      else $error("frame peak below one");
   a_no_active_no_sum: assert property (@(posedge clock) disable iff (reset)
      (act_ff == 7'd0) |-> (dev_ff == 24'd0))
      else $error("deviation sum without active subcarrier");
   a_bar_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (bar_idx_ff < pos_ff))
      else $error("bar index outside frame");
endmodule

@@ src/csimt_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on csimt_pkg.
module csimt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  csimt_pkg::div_req_type req,
   output csimt_pkg::div_rsp_type rsp
);
   logic [csimt_pkg::DIV_W-1:0]  dvd_ff, dvd_in;
   logic [csimt_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [csimt_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [csimt_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [csimt_pkg::DVS_W:0]    shift;
   logic [csimt_pkg::DVS_W+1:0]  trial;

   always_comb begin
      shift   = {rem_ff, dvd_ff[csimt_pkg::DIV_W-1]};
      trial   = {1'b0, shift} - {2'b00, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in = req.dividend;
         dvs_in = req.divisor;
         rem_in = '0;
         cnt_in = csimt_pkg::DCNT_W'(csimt_pkg::DIV_W);
      end else if (cnt_ff != '0) begin
         if (!trial[csimt_pkg::DVS_W+1]) begin
            rem_in = trial[csimt_pkg::DVS_W-1:0];
            dvd_in = {dvd_ff[csimt_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shift[csimt_pkg::DVS_W-1:0];
            dvd_in = {dvd_ff[csimt_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == csimt_pkg::DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;
endmodule

@@ src/csimt_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on csimt_pkg.
module csimt_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  csimt_pkg::sqrt_req_type req,
   output csimt_pkg::sqrt_rsp_type rsp
);
   logic [csimt_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [csimt_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [csimt_pkg::ROOT_W+3:0] rem_ff, rem_in;
   logic [csimt_pkg::SCNT_W-1:0] cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [csimt_pkg::ROOT_W+3:0] rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff[csimt_pkg::ROOT_W+1:0], rad_ff[csimt_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rad_in  = req.radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = csimt_pkg::SCNT_W'(csimt_pkg::ROOT_W);
      end else if (cnt_ff != '0) begin
         rad_in = {rad_ff[csimt_pkg::RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[csimt_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[csimt_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == csimt_pkg::SCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for csi_motion_turbulence: random and directed subcarrier beats,
// bar-by-bar comparison against an in-bench turbulence predictor.
// Depends on csimt_pkg and the block under src.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             cmd;
      logic signed [7:0] im;
      logic signed [7:0] re;
      logic             inv;
      logic             fend;
   } sample_type;

   typedef struct packed {
      logic [5:0]  idx;
      logic [7:0]  bar;
      logic [15:0] turb;
      logic [6:0]  cnt;
      logic        last;
   } bar_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_cmd = 0, req_invalid_flag = 0, req_frame_end = 0;
   logic signed [7:0] req_imag_part = 0, req_real_part = 0;
   logic req_ready, rsp_valid, rsp_ready = 0;
   logic [5:0] rsp_subcarrier_index;
   logic [7:0] rsp_amplitude_bar;
   logic [15:0] rsp_turbulence;
   logic [6:0] rsp_subcarrier_count;
   logic rsp_last_bar;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   logic csr_pready;

   csi_motion_turbulence u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [15:0] p_slow_alpha = csimt_pkg::SLOW_ALPHA_RST;
   logic [15:0] p_out_alpha = csimt_pkg::OUT_ALPHA_RST;
   logic [15:0] p_floor = csimt_pkg::ACTIVE_FLOOR_RST;
   logic [15:0] p_mean [csimt_pkg::SUBCARRIERS];
   logic [15:0] p_frames = 0, p_turb = 0, p_peak = csimt_pkg::PEAK_RST;
   logic [23:0] p_devsum = 0;
   logic [6:0]  p_active = 0, p_pos = 0;
   logic [7:0]  p_bars [csimt_pkg::SUBCARRIERS];

   sample_type pending_q[$];
   bar_type    bars_due_q[$];
   int mismatches = 0, bars_seen = 0, frames_sent = 0, idle_cycles = 0;

   function automatic logic [15:0] blend16(logic [15:0] m, logic [31:0] x, logic [16:0] w);
      longint d, mag, q, r;
      d = longint'(x) - longint'(m);
      mag = d < 0 ? -d : d;
      q = (longint'(w) * mag + 32768) >> 16;
      r = d < 0 ? longint'(m) - q : longint'(m) + q;
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return r[15:0];
   endfunction

   function automatic logic [15:0] amp_of(logic signed [7:0] im, logic signed [7:0] re);
      longint s, r;
      s = (longint'(im) * im + longint'(re) * re) * 65536;
      r = 0;
      while ((r + 1) * (r + 1) <= s) r++;
      return r[15:0];
   endfunction

   task automatic forget_frame();
      p_devsum = 0; p_active = 0; p_peak = csimt_pkg::PEAK_RST; p_pos = 0;
      foreach (p_bars[i]) p_bars[i] = 0;
   endtask

   task automatic predict_turbulence(sample_type s);
      logic [15:0] amp, m;
      logic [16:0] w;
      longint dv, rel;
      bar_type b;
      longint bv;
      logic [csimt_pkg::IDX_W-1:0] pi;
      if (s.cmd == csimt_pkg::CMD_CLEAR) begin
         foreach (p_mean[i]) p_mean[i] = 0;
         p_frames = 0; p_turb = 0;
         forget_frame();
         return;
      end
      if (p_pos == 0 && p_frames != 16'hFFFF) p_frames++;
      if (p_pos < csimt_pkg::SUBCARRIERS) begin
         pi = p_pos[csimt_pkg::IDX_W-1:0];
         if (!s.inv) begin
            amp = amp_of(s.im, s.re);
            w = p_frames != 0 ? 17'(65536 / p_frames) : 17'h10000;
            if (w < {1'b0, p_slow_alpha}) w = {1'b0, p_slow_alpha};
            m = p_mean[pi];
            m = (m == 0) ? amp : blend16(m, {16'd0, amp}, w);
            p_mean[pi] = m;
            if (m > p_floor) begin
               dv = amp > m ? longint'(amp) - longint'(m) : longint'(m) - longint'(amp);
               rel = (dv * 256) / m;
               if (rel > 65535) rel = 65535;
               rel = rel + p_devsum;
               p_devsum = rel > csimt_pkg::DEV_MAX ? csimt_pkg::DEV_MAX : rel[23:0];
               if (p_active < 127) p_active++;
            end
            if (amp > p_peak) p_peak = amp;
            p_bars[pi] = amp[15:8];
         end else
            p_bars[pi] = 0;
         p_pos++;
      end
      if (!s.fend) return;
      if (p_active > 0)
         p_turb = blend16(p_turb, 32'(p_devsum / p_active), {1'b0, p_out_alpha});
      for (int i = 0; i < p_pos; i++) begin
         bv = (longint'(p_bars[i]) * 65280) / p_peak;
         b.idx = i[5:0];
         b.bar = bv > 255 ? 8'd255 : bv[7:0];
         b.turb = p_turb;
         b.cnt = p_pos;
         b.last = (i + 1 == p_pos);
         bars_due_q.push_back(b);
      end
      forget_frame();
   endtask

   // driver
   int req_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_wait <= $urandom_range(0, 13);
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_turbulence({req_cmd, req_imag_part, req_real_part,
                                            req_invalid_flag, req_frame_end});
         if (req_wait > 0 || pending_q.size() == 0) begin
            req_valid <= 0;
            if (req_wait > 0) req_wait <= req_wait - 1;
         end else begin
            sample_type s;
            s = pending_q.pop_front();
            req_valid <= 1;
            {req_cmd, req_imag_part, req_real_part, req_invalid_flag, req_frame_end} <= s;
            req_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         end
      end
   end

   // monitor
   int rsp_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bar_type got, exp_b;
            got = {rsp_subcarrier_index, rsp_amplitude_bar, rsp_turbulence,
                   rsp_subcarrier_count, rsp_last_bar};
            bars_seen++;
            if (bars_due_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected bar %h", got);
            end else begin
               exp_b = bars_due_q.pop_front();
               if (got !== exp_b) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("bar mismatch: exp idx %0d bar %0d turb %0d cnt %0d last %0d",
                        exp_b.idx, exp_b.bar, exp_b.turb, exp_b.cnt, exp_b.last);
                     $display("              got idx %0d bar %0d turb %0d cnt %0d last %0d",
                        got.idx, got.bar, got.turb, got.cnt, got.last);
                  end
               end
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if (rsp_valid && rsp_ready)
               rsp_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= {16'h0, val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         csimt_pkg::REG_SLOW_ALPHA: p_slow_alpha = val;
         csimt_pkg::REG_OUT_ALPHA:  p_out_alpha = val;
         default:                   p_floor = val;
      endcase
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_valid || bars_due_q.size() != 0 || !req_ready)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic queue_frame(int n);
      sample_type s;
      for (int i = 0; i < n; i++) begin
         s.cmd = csimt_pkg::CMD_SAMPLE;
         s.im = 8'($urandom); s.re = 8'($urandom);
         if ($urandom_range(0, 1)) begin
            s.im = 8'sd40 + $signed(8'($urandom_range(0, 8)));
            s.re = -8'sd30;
         end
         s.inv = ($urandom_range(0, 9) == 0);
         s.fend = (i == n - 1);
         pending_q.push_back(s);
      end
      frames_sent++;
   endtask

   initial begin
      foreach (p_mean[i]) p_mean[i] = 0;
      foreach (p_bars[i]) p_bars[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      // directed: extremes, invalid, clear, single-sample frames
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sh80, 8'sh80, 1'b0, 1'b0});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd127, 8'sd127, 1'b0, 1'b0});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd0, 8'sd0, 1'b0, 1'b0});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sh80, 8'sd127, 1'b1, 1'b1});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd5, -8'sd3, 1'b0, 1'b1});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd60, 8'sd10, 1'b0, 1'b1});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd61, 8'sd12, 1'b0, 1'b1});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd1, 8'sd1, 1'b0, 1'b0});
      pending_q.push_back({csimt_pkg::CMD_CLEAR, 8'sd127, -8'sd1, 1'b1, 1'b1});
      pending_q.push_back({csimt_pkg::CMD_SAMPLE, 8'sd0, 8'sd0, 1'b1, 1'b1});
      drain();
      csr_write(csimt_pkg::REG_SLOW_ALPHA, 16'hFFFF);
      csr_write(csimt_pkg::REG_OUT_ALPHA, 16'hFFFF);
      csr_write(csimt_pkg::REG_ACTIVE_FLOOR, 16'h0000);
      queue_frame(4); queue_frame(3);
      drain();
      csr_write(csimt_pkg::REG_SLOW_ALPHA, 16'd1);
      csr_write(csimt_pkg::REG_OUT_ALPHA, 16'd1);
      csr_write(csimt_pkg::REG_ACTIVE_FLOOR, 16'hFFFF);
      queue_frame(3);
      drain();
      // overflow frame: more than SUBCARRIERS samples
      csr_write(csimt_pkg::REG_SLOW_ALPHA, csimt_pkg::SLOW_ALPHA_RST);
      csr_write(csimt_pkg::REG_OUT_ALPHA, csimt_pkg::OUT_ALPHA_RST);
      csr_write(csimt_pkg::REG_ACTIVE_FLOOR, csimt_pkg::ACTIVE_FLOOR_RST);
      queue_frame(csimt_pkg::SUBCARRIERS + 2);
      drain();
      for (int k = 0; k < 8; k++) begin
         if ($urandom_range(0, 12) == 0)
            pending_q.push_back({csimt_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom),
                                 1'b0, 1'b0});
         queue_frame($urandom_range(1, 4));
         if (k % 4 == 3) begin
            drain();
            csr_write(csimt_pkg::REG_SLOW_ALPHA, 16'($urandom_range(1, 65535)));
            csr_write(csimt_pkg::REG_OUT_ALPHA, 16'($urandom_range(1, 65535)));
            csr_write(csimt_pkg::REG_ACTIVE_FLOOR, 16'($urandom_range(0, 2000)));
         end
      end
      drain();
      $display("Covered %0d frames and %0d bars, including clears, invalid samples and overflow.",
               frames_sent, bars_seen);
      if (mismatches == 0 && bars_due_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
